// File: sv/gfsr_r1279_generator_core_defines.svh
// ---------------------------------------------------------------------------
// GFSR R1279 generator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef GFSR_R1279_GENERATOR_CORE_DEFINES_SVH
`define GFSR_R1279_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication
`define GFSR_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GFSR_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/gfsr_pkg.sv
// ---------------------------------------------------------------------------
// GFSR package
// Constants, request and status codes, sequencer states and the
// Park-Miller fold shared by the generator files.
// ---------------------------------------------------------------------------
package gfsr_pkg;

    localparam int TABLE_LEN_DEF = 1279;
    localparam int SHORT_LAG_DEF = 1063;

    localparam logic [14:0] PM_MULT = 15'd16807;
    localparam logic [30:0] PM_MOD  = 31'h7fffffff;

    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_SEED = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_UNSEEDED = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAW,
        S_SEED_MUL,
        S_SEED_RED,
        S_EMIT
    } state_t;

    // reduce a value below twice the modulus
    function automatic logic [30:0] pm_fold(input logic [31:0] s);
        logic [31:0] t;
        t = s - {1'b0, PM_MOD};
        pm_fold = (s >= {1'b0, PM_MOD}) ? t[30:0] : s[30:0];
    endfunction

endpackage

// File: sv/gfsr_pm_step.sv
// ---------------------------------------------------------------------------
// GFSR Park-Miller step
// Registered multiply by 16807, then fold modulo 2^31 - 1.
// ---------------------------------------------------------------------------
module gfsr_pm_step
(
    input  logic        clk,
    input  logic [30:0] x,
    output logic [30:0] y
);

    logic [45:0] prod_reg;
    logic [31:0] fold_sum;

    always_ff @(posedge clk)
    begin
        prod_reg <= {15'd0, x} * {31'd0, gfsr_pkg::PM_MULT};
    end

    assign fold_sum = {17'd0, prod_reg[45:31]} + {1'b0, prod_reg[30:0]};
    assign y        = gfsr_pkg::pm_fold(fold_sum);

endmodule

// File: sv/gfsr_r1279_generator_core.sv
// ---------------------------------------------------------------------------
// GFSR R1279 generator core
// XOR lagged-Fibonacci generator over a lag table in block memory,
// seeded from a Park-Miller sequence.
// ---------------------------------------------------------------------------
//
//  channel  | dir | tdata      | tuser        | notes
//  ---------+-----+------------+--------------+------------------------------
//  s_*      | in  | seed[31:0] | req_type[0]  | 0 draw, 1 seed
//  m_*      | out | value[31:0]| status[1:0]  | 0 ok, 1 unseeded, 2 rejected
//
//  Draw: memory read registered, then XOR and write-back in the draw state.
//  Seed: each table word takes two Park-Miller steps of multiply and fold.
//  Rejects: result registered at accept, or held in S_EMIT while stalled.
//  Reset clears the lead and fill indices and the seeded flag and loads the
//  tap index with its start offset; table content is undefined until
//  seeded. A stalled result holds the core off the input side.
// ---------------------------------------------------------------------------
`include "gfsr_r1279_generator_core_defines.svh"

module gfsr_r1279_generator_core
#(
    parameter int TABLE_LEN = gfsr_pkg::TABLE_LEN_DEF,
    parameter int SHORT_LAG = gfsr_pkg::SHORT_LAG_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] seed
    input  logic [0:0]  s_tuser,   // [0] req_type

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int IDX_W     = $clog2(TABLE_LEN);
    localparam int TAP_START = (2 * TABLE_LEN - (SHORT_LAG % TABLE_LEN)) % TABLE_LEN;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_TAP  = IDX_W'(TAP_START);

    gfsr_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0] lead_reg, lead_next;
    logic [IDX_W-1:0] tap_reg, tap_next;
    logic [IDX_W-1:0] fill_reg, fill_next;
    logic             seeded_reg, seeded_next;
    logic             half_reg, half_next;
    logic [30:0]      lcg_reg, lcg_next;
    logic [15:0]      hi_reg, hi_next;

    logic [31:0] res_value_reg;
    logic [1:0]  res_status_reg;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    logic [31:0] mem [TABLE_LEN];
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_data;

    logic        accept;
    logic        out_free;
    logic        seed_bad;
    logic        fin_valid;
    logic [31:0] fin_value;
    logic [1:0]  fin_status;
    logic [30:0] pm_y;
    logic [30:0] seed_fold;
    logic [IDX_W-1:0] lead_inc;
    logic [IDX_W-1:0] tap_inc;
    logic [IDX_W-1:0] fill_inc;

    gfsr_pm_step u_pm_step
    (
        .clk (clk),
        .x   (lcg_reg),
        .y   (pm_y)
    );

    assign s_tready  = (state_reg == gfsr_pkg::S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign seed_bad  = (s_tdata == 32'h0) || (s_tdata == 32'hffffffff);
    assign seed_fold = gfsr_pkg::pm_fold({31'd0, s_tdata[31]} + {1'b0, s_tdata[30:0]});
    assign lead_inc  = (lead_reg == IDX_LAST) ? '0 : lead_reg + 1'b1;
    assign tap_inc   = (tap_reg == IDX_LAST) ? '0 : tap_reg + 1'b1;
    assign fill_inc  = fill_reg + 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gfsr_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[0] == gfsr_pkg::REQ_SEED)
                    begin
                        if (seed_bad)
                        begin
                            state_next = out_free ? gfsr_pkg::S_IDLE : gfsr_pkg::S_EMIT;
                        end
                        else
                        begin
                            state_next = gfsr_pkg::S_SEED_MUL;
                        end
                    end
                    else if (seeded_reg)
                    begin
                        state_next = gfsr_pkg::S_DRAW;
                    end
                    else
                    begin
                        state_next = out_free ? gfsr_pkg::S_IDLE : gfsr_pkg::S_EMIT;
                    end
                end
            end
            gfsr_pkg::S_DRAW:
            begin
                state_next = out_free ? gfsr_pkg::S_IDLE : gfsr_pkg::S_EMIT;
            end
            gfsr_pkg::S_SEED_MUL:
            begin
                state_next = gfsr_pkg::S_SEED_RED;
            end
            gfsr_pkg::S_SEED_RED:
            begin
                if (half_reg && (fill_reg == IDX_LAST))
                begin
                    state_next = out_free ? gfsr_pkg::S_IDLE : gfsr_pkg::S_EMIT;
                end
                else
                begin
                    state_next = gfsr_pkg::S_SEED_MUL;
                end
            end
            gfsr_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = gfsr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gfsr_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and results
    always_comb
    begin
        lead_next   = lead_reg;
        tap_next    = tap_reg;
        fill_next   = fill_reg;
        seeded_next = seeded_reg;
        half_next   = half_reg;
        lcg_next    = lcg_reg;
        hi_next     = hi_reg;
        wr_en       = 1'b0;
        wr_addr     = lead_reg;
        wr_data     = rd_a_reg ^ rd_b_reg;
        fin_valid   = 1'b0;
        fin_value   = 32'h0;
        fin_status  = gfsr_pkg::ST_OK;
        case (state_reg)
            gfsr_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser[0] == gfsr_pkg::REQ_SEED)
                    begin
                        if (seed_bad)
                        begin
                            fin_valid  = 1'b1;
                            fin_status = gfsr_pkg::ST_REJECTED;
                        end
                        else
                        begin
                            lcg_next  = seed_fold;
                            fill_next = '0;
                            half_next = 1'b0;
                        end
                    end
                    else if (!seeded_reg)
                    begin
                        fin_valid  = 1'b1;
                        fin_status = gfsr_pkg::ST_UNSEEDED;
                    end
                end
            end
            gfsr_pkg::S_DRAW:
            begin
                wr_en     = 1'b1;
                lead_next = lead_inc;
                tap_next  = tap_inc;
                fin_valid = 1'b1;
                fin_value = rd_a_reg ^ rd_b_reg;
            end
            gfsr_pkg::S_SEED_MUL:
            begin
            end
            gfsr_pkg::S_SEED_RED:
            begin
                lcg_next  = pm_y;
                half_next = !half_reg;
                if (!half_reg)
                begin
                    hi_next = pm_y[23:8];
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = fill_reg;
                    wr_data = {hi_reg, pm_y[23:8]};
                    if (fill_reg == IDX_LAST)
                    begin
                        fill_next   = '0;
                        lead_next   = '0;
                        tap_next    = IDX_TAP;
                        seeded_next = 1'b1;
                        fin_valid   = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end
            end
            gfsr_pkg::S_EMIT:
            begin
                fin_valid  = 1'b1;
                fin_value  = res_value_reg;
                fin_status = res_status_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= gfsr_pkg::S_IDLE;
            lead_reg     <= '0;
            tap_reg      <= IDX_TAP;
            fill_reg     <= '0;
            seeded_reg   <= 1'b0;
            half_reg     <= 1'b0;
            lcg_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            lead_reg   <= lead_next;
            tap_reg    <= tap_next;
            fill_reg   <= fill_next;
            seeded_reg <= seeded_next;
            half_reg   <= half_next;
            lcg_reg    <= lcg_next;
            if (fin_valid && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        if (fin_valid && out_free)
        begin
            m_tdata_reg <= fin_value;
            m_tuser_reg <= fin_status;
        end
        if (fin_valid && !out_free)
        begin
            res_value_reg  <= fin_value;
            res_status_reg <= fin_status;
        end
    end

    // lag table: two registered reads, one write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[lead_reg];
        rd_b_reg <= mem[tap_reg];
    end

    `GFSR_CHECK_NEXT(a_draw_reads,
        accept && (s_tuser[0] == gfsr_pkg::REQ_DRAW) && seeded_reg,
        state_reg == gfsr_pkg::S_DRAW,
        "seeded draw did not enter the read state")

    `GFSR_CHECK(a_lag_distance,
        1'b1,
        ((32'(lead_reg) + 32'(TAP_START) < 32'(TABLE_LEN))
            ? (32'(tap_reg) == 32'(lead_reg) + 32'(TAP_START))
            : (32'(tap_reg) == 32'(lead_reg) + 32'(TAP_START) - 32'(TABLE_LEN))),
        "lead and tap indices lost their lag distance")

    `GFSR_CHECK(a_fill_idle,
        state_reg == gfsr_pkg::S_IDLE,
        fill_reg == '0,
        "fill counter nonzero outside a seed fill")

endmodule

// File: dv/gfsr_r1279_generator_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// GFSR R1279 generator core testbench
// Drives draw and seed words into the core and checks each result word
// against an in-bench lagged-Fibonacci predictor with its own lag table and
// minimal-standard fill. Covers unseeded draws, rejected seeds, seeds at and
// above the modulus, long draw runs, long output back-pressure and random
// mixes with idle bursts on both sides.
// ---------------------------------------------------------------------------
module gfsr_r1279_generator_core_tb;

    localparam int          N_WORDS      = gfsr_pkg::TABLE_LEN_DEF;
    localparam int          TAP_HOME     =
        (2 * gfsr_pkg::TABLE_LEN_DEF - gfsr_pkg::SHORT_LAG_DEF % gfsr_pkg::TABLE_LEN_DEF)
        % gfsr_pkg::TABLE_LEN_DEF;
    localparam logic [63:0] MINSTD_MULT  = 64'd16807;
    localparam logic [63:0] MINSTD_MOD   = 64'h7fffffff;
    localparam logic [31:0] SEED_ONES    = 32'hffffffff;
    localparam int          QUIET_LIMIT  = 20000;
    localparam int          LONG_HOLD    = 400;
    localparam int          SHOWN_ERRORS = 10;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } gen_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    logic [31:0] lag_mem [N_WORDS];
    int          lead_ix = 0;
    int          tap_ix  = TAP_HOME;
    bit          seeded  = 1'b0;

    gen_word_t   pending_words [$];
    int unsigned error_count  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left    = 0;
    int unsigned stall_left   = 0;
    bit          gaps_on      = 1'b1;
    bit          stalls_on    = 1'b1;

    gfsr_r1279_generator_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] minstd_next(input logic [31:0] x);
        logic [63:0] p;
        p = MINSTD_MULT * {32'd0, x};
        return 32'(p % MINSTD_MOD);
    endfunction

    function automatic gen_word_t gfsr_predict(input logic req, input logic [31:0] seed);
        gen_word_t   r;
        logic [31:0] w;
        logic [31:0] hi;
        logic [31:0] lo;
        r.value  = '0;
        r.status = gfsr_pkg::ST_OK;
        if (req == gfsr_pkg::REQ_SEED)
        begin
            if (seed == 32'd0 || seed == SEED_ONES)
                r.status = gfsr_pkg::ST_REJECTED;
            else
            begin
                w = 32'({32'd0, seed} % MINSTD_MOD);
                for (int i = 0; i < N_WORDS; i++)
                begin
                    w  = minstd_next(w);
                    hi = (w << 8) & 32'hffff0000;
                    w  = minstd_next(w);
                    lo = (w >> 8) & 32'h0000ffff;
                    lag_mem[i] = hi | lo;
                end
                lead_ix = 0;
                tap_ix  = TAP_HOME;
                seeded  = 1'b1;
            end
        end
        else if (!seeded)
            r.status = gfsr_pkg::ST_UNSEEDED;
        else
        begin
            r.value          = lag_mem[lead_ix] ^ lag_mem[tap_ix];
            lag_mem[lead_ix] = r.value;
            lead_ix          = (lead_ix + 1 == N_WORDS) ? 0 : lead_ix + 1;
            tap_ix           = (tap_ix + 1 == N_WORDS) ? 0 : tap_ix + 1;
        end
        return r;
    endfunction

    task automatic check_word();
        gen_word_t want;
        if (pending_words.size() == 0)
        begin
            error_count++;
            if (error_count <= SHOWN_ERRORS)
                $display("unexpected word: value %h status %0d", m_tdata, m_tuser);
        end
        else
        begin
            want = pending_words.pop_front();
            if (m_tdata !== want.value || m_tuser !== want.status)
            begin
                error_count++;
                if (error_count <= SHOWN_ERRORS)
                    $display("mismatch: expected value %h status %0d, got value %h status %0d",
                             want.value, want.status, m_tdata, m_tuser);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_word();
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("gfsr_r1279_generator_core verification failed");
            $finish;
        end
    end

    task automatic send_word(input logic req, input logic [31:0] seed);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= seed;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_words.push_back(gfsr_predict(req, seed));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
    endtask

    function automatic logic [31:0] good_seed();
        logic [31:0] sd;
        do
            sd = $urandom;
        while (sd == 32'd0 || sd == SEED_ONES);
        return sd;
    endfunction

    task automatic test_unseeded();
        send_word(gfsr_pkg::REQ_DRAW, $urandom);
        send_word(gfsr_pkg::REQ_DRAW, SEED_ONES);
        send_word(gfsr_pkg::REQ_SEED, 32'd0);
        send_word(gfsr_pkg::REQ_SEED, SEED_ONES);
        send_word(gfsr_pkg::REQ_DRAW, 32'd0);
    endtask

    task automatic test_seed_extremes();
        send_word(gfsr_pkg::REQ_SEED, 32'd1);
        repeat (3) send_word(gfsr_pkg::REQ_DRAW, $urandom);
        send_word(gfsr_pkg::REQ_SEED, 32'd0);
        send_word(gfsr_pkg::REQ_DRAW, $urandom);
        send_word(gfsr_pkg::REQ_SEED, 32'h7fffffff);
        repeat (2) send_word(gfsr_pkg::REQ_DRAW, $urandom);
        send_word(gfsr_pkg::REQ_SEED, 32'hfffffffe);
        send_word(gfsr_pkg::REQ_DRAW, $urandom);
        send_word(gfsr_pkg::REQ_SEED, 32'h80000000);
        repeat (2) send_word(gfsr_pkg::REQ_DRAW, $urandom);
        send_word(gfsr_pkg::REQ_SEED, 32'h7ffffffe);
        repeat (2) send_word(gfsr_pkg::REQ_DRAW, $urandom);
        send_word(gfsr_pkg::REQ_SEED, SEED_ONES);
        send_word(gfsr_pkg::REQ_DRAW, $urandom);
    endtask

    task automatic test_backpressure();
        drain_results();
        hold_request = LONG_HOLD;
        repeat (24) send_word(gfsr_pkg::REQ_DRAW, $urandom);
        drain_results();
    endtask

    task automatic test_draw_run();
        send_word(gfsr_pkg::REQ_SEED, good_seed());
        repeat (400) send_word(gfsr_pkg::REQ_DRAW, $urandom);
    endtask

    task automatic test_random(input int unsigned count);
        int unsigned pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 199);
            if (pick < 2)
                send_word(gfsr_pkg::REQ_SEED, good_seed());
            else if (pick < 8)
                send_word(gfsr_pkg::REQ_SEED, pick[0] ? SEED_ONES : 32'd0);
            else
                send_word(gfsr_pkg::REQ_DRAW, $urandom);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = gfsr_pkg::REQ_DRAW;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unseeded();
        test_seed_extremes();
        test_backpressure();
        test_draw_run();
        test_random(220);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        test_random(80);

        drain_results();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("gfsr_r1279_generator_core verification clean");
        else
            $display("gfsr_r1279_generator_core verification failed");
        $finish;
    end

endmodule
